>>> rtl/assert_macros.svh
// shared assertion macros, clocked on clk and held off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define MMQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define MMQ_ASSERT_IMPL(label, ante, cons, msg) \
	`MMQ_ASSERT(label, (ante) |-> (cons), msg)

`endif

>>> rtl/mmq_pkg.sv
`timescale 1ns / 1ps

package mmq_pkg;

	// sample format
	localparam int SAMPLE_W   = 24;
	localparam int FRAC_BITS  = 12;

	// quantisation parameters
	localparam int CODE_W     = 8;
	localparam int CODE_MAX   = (1 << CODE_W) - 1;
	localparam int RECIP_W    = 32;
	localparam int RECIP_FRAC = 16;
	localparam int RECIP_HW   = RECIP_W / 2;
	localparam int SCALE_W    = 17;
	localparam int PROD_SHIFT = FRAC_BITS + RECIP_FRAC;

	// affine datapath widths
	localparam int MAG_W  = SAMPLE_W + 1;
	localparam int PP_W   = MAG_W + RECIP_HW;
	localparam int PROD_W = MAG_W + RECIP_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (PROD_SHIFT - 1);

	// reciprocal divider
	localparam int NUM_W     = CODE_W + PROD_SHIFT + 1;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);
	localparam logic [NUM_W-1:0] DIV_NUM = NUM_W'(CODE_MAX) << PROD_SHIFT;

	// scale by multiply with reciprocal of 255
	localparam int DSC_W      = SAMPLE_W + 1;
	localparam int SC_SHIFT   = DSC_W + 8;
	localparam int SC_MULT_W  = SC_SHIFT - 7;
	localparam longint unsigned SC_MULT_L =
		((64'd1 << SC_SHIFT) + 64'd254) / 64'd255;
	localparam logic [SC_MULT_W-1:0] SC_MULT = SC_MULT_W'(SC_MULT_L);
	localparam int SC_PROD_W  = DSC_W + SC_MULT_W;
	localparam int SC_ROUND   = 127;

	// command queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// field codes
	localparam logic MODE_CAL     = 1'b0;
	localparam logic MODE_QUANT   = 1'b1;
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_CODE    = 1'b1;

	typedef struct packed {
		logic                       mode;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_item;
	} in_word_t;

	typedef struct packed {
		logic                       kind;
		logic [CODE_W-1:0]          code;
		logic [CODE_W-1:0]          zero_point_out;
		logic signed [SAMPLE_W-1:0] min_out;
		logic signed [SAMPLE_W-1:0] max_out;
		logic [SCALE_W-1:0]         scale_out;
		logic                       degenerate;
	} out_word_t;

	// queued command: a sample to quantise, or a summary with min and max
	typedef struct packed {
		logic                       summary;
		logic signed [SAMPLE_W-1:0] a;
		logic signed [SAMPLE_W-1:0] b;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic zero;
	} div_stat_t;

	typedef struct packed {
		logic                    valid;
		logic                    tag_zp;
		logic                    deg;
		logic [CODE_W-1:0]       zp;
		logic [RECIP_W-1:0]      recip;
		logic signed [MAG_W-1:0] x;
	} aff_in_t;

	typedef struct packed {
		logic              valid;
		logic              tag_zp;
		logic              deg;
		logic [CODE_W-1:0] zp;
		logic [CODE_W-1:0] code;
	} aff_out_t;

endpackage

>>> rtl/mmq_front.sv
`timescale 1ns / 1ps

module mmq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  mmq_pkg::in_word_t item,
	input  logic              fifo_full,
	output logic              push,
	output mmq_pkg::cmd_t     push_cmd
);
	import mmq_pkg::*;

	logic signed [SAMPLE_W-1:0] run_min_q;
	logic signed [SAMPLE_W-1:0] run_max_q;
	logic signed [SAMPLE_W-1:0] lo;
	logic signed [SAMPLE_W-1:0] hi;
	logic                       accept;
	logic                       is_cal;

	assign item_stall = fifo_full;
	assign accept     = item_valid && !item_stall;
	assign is_cal     = (item.mode == MODE_CAL);

	// min and max compared independently
	assign lo = (item.sample < run_min_q) ? item.sample : run_min_q;
	assign hi = (item.sample > run_max_q) ? item.sample : run_max_q;

	assign push             = accept && (!is_cal || item.last_item);
	assign push_cmd.summary = is_cal;
	assign push_cmd.a       = is_cal ? lo : item.sample;
	assign push_cmd.b       = hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= {1'b0, {(SAMPLE_W-1){1'b1}}};
			run_max_q <= {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else if (accept && is_cal) begin
			if (item.last_item) begin
				// fresh data set after a summary
				run_min_q <= {1'b0, {(SAMPLE_W-1){1'b1}}};
				run_max_q <= {1'b1, {(SAMPLE_W-1){1'b0}}};
			end else begin
				run_min_q <= lo;
				run_max_q <= hi;
			end
		end
	end

endmodule

>>> rtl/mmq_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmq_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mmq_pkg::cmd_t push_cmd,
	input  logic          pop,
	output mmq_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);
	import mmq_pkg::*;

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`MMQ_ASSERT(a_fifo_count_bound, count_q <= FIFO_CW'(FIFO_DEPTH), "queue count past depth")
	`MMQ_ASSERT_IMPL(a_fifo_pop_nonempty, pop, !empty, "pop from empty queue")

endmodule

>>> rtl/mmq_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mmq_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [mmq_pkg::SAMPLE_W-1:0]  range,
	output mmq_pkg::div_stat_t            stat,
	output logic [mmq_pkg::RECIP_W-1:0]   recip,
	output logic [mmq_pkg::SCALE_W-1:0]   scale
);
	import mmq_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic                 zero_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [SAMPLE_W-1:0]  den_q;
	logic [SAMPLE_W-1:0]  rem_q;
	logic [NUM_W-1:0]     quo_q;
	logic [DSC_W-1:0]     dsc_q;
	logic [SC_PROD_W-1:0] sc_prod_q;
	logic [SAMPLE_W:0]    sh;
	logic [SAMPLE_W:0]    diff;
	logic                 ge;

	// one quotient bit per cycle, restoring
	assign sh   = {rem_q, quo_q[NUM_W-1]};
	assign diff = sh - {1'b0, den_q};
	assign ge   = (sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			zero_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				zero_q <= (range == '0);
				if (range == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= DIV_CNT_W'(NUM_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= range;
			rem_q <= '0;
			quo_q <= DIV_NUM + NUM_W'(range >> 1);
			dsc_q <= DSC_W'(range) + DSC_W'(SC_ROUND);
		end else if (busy_q) begin
			rem_q <= ge ? diff[SAMPLE_W-1:0] : sh[SAMPLE_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
		sc_prod_q <= SC_PROD_W'(dsc_q) * SC_PROD_W'(SC_MULT);
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.zero = zero_q;

	always_comb begin
		if (zero_q) begin
			recip = '0;
		end else if (|quo_q[NUM_W-1:RECIP_W]) begin
			recip = '1;
		end else begin
			recip = quo_q[RECIP_W-1:0];
		end
	end

	assign scale = zero_q ? '0 : sc_prod_q[SC_SHIFT +: SCALE_W];

	`MMQ_ASSERT_IMPL(a_div_count_live, busy_q, cnt_q != '0, "divider busy with spent count")

endmodule

>>> rtl/mmq_affine.sv
`timescale 1ns / 1ps

module mmq_affine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  mmq_pkg::aff_in_t   in,
	output mmq_pkg::aff_out_t  out
);
	import mmq_pkg::*;

	logic [4:0]          valid_q;
	logic [4:0]          tag_q;
	logic [4:0]          deg_q;
	logic [CODE_W-1:0]   zp_s1, zp_s2, zp_s3, zp_s4, zp_s5;
	logic [3:0]          neg_q;
	logic [MAG_W-1:0]    mag_s1;
	logic [RECIP_W-1:0]  recip_s1;
	logic [PP_W-1:0]     pp_lo_s2;
	logic [PP_W-1:0]     pp_hi_s2;
	logic [PROD_W-1:0]   p_s3;
	logic [ACC_W-1:0]    t_s4;
	logic                under_s4;
	logic [CODE_W-1:0]   code_s5;
	logic                x_neg;
	logic [MAG_W-1:0]    mag;
	logic [ACC_W-1:0]    zs;
	logic [ACC_W-1:0]    p_ext;
	logic [ACC_W-1:0]    rnd;
	logic [CODE_W-1:0]   code;

	assign x_neg = in.x[MAG_W-1];
	assign mag   = x_neg ? MAG_W'(-in.x) : MAG_W'(in.x);
	assign zs    = ACC_W'(zp_s3) << PROD_SHIFT;
	assign p_ext = ACC_W'(p_s3);
	assign rnd   = t_s4 + ROUND_HALF;

	always_comb begin
		if (under_s4) begin
			code = '0;
		end else if (|rnd[ACC_W-1:PROD_SHIFT+CODE_W]) begin
			code = CODE_W'(CODE_MAX);
		end else begin
			code = rnd[PROD_SHIFT +: CODE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[3:0], in.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_q <= {tag_q[3:0], in.tag_zp};
			deg_q <= {deg_q[3:0], in.deg};
			neg_q <= {neg_q[2:0], x_neg};
			// magnitude
			zp_s1    <= in.zp;
			mag_s1   <= mag;
			recip_s1 <= in.recip;
			// two half-width partial products
			zp_s2    <= zp_s1;
			pp_lo_s2 <= PP_W'(mag_s1) * PP_W'(recip_s1[RECIP_HW-1:0]);
			pp_hi_s2 <= PP_W'(mag_s1) * PP_W'(recip_s1[RECIP_W-1:RECIP_HW]);
			// full product
			zp_s3    <= zp_s2;
			p_s3     <= {pp_hi_s2, {RECIP_HW{1'b0}}} + PROD_W'(pp_lo_s2);
			// add or subtract against shifted zero point
			zp_s4    <= zp_s3;
			under_s4 <= neg_q[2] && (zs < p_ext);
			t_s4     <= neg_q[2] ? (zs - p_ext) : (zs + p_ext);
			// round half up and clamp
			zp_s5    <= zp_s4;
			code_s5  <= code;
		end
	end

	assign out.valid  = valid_q[4];
	assign out.tag_zp = tag_q[4];
	assign out.deg    = deg_q[4];
	assign out.zp     = zp_s5;
	assign out.code   = code_s5;

endmodule

>>> rtl/minmax_uint8_quantizer.sv
// two-pass affine uint8 quantiser for signed q12.12 samples
// input channel item: mode 0 words are calibration samples, mode 1 words are
// samples to quantise; last_item on a calibration word closes the data set
// output channel result: one word per quantise sample (kind 1, code), one
// summary word per closed data set (kind 0, min, max, scale, zero point)
// calibration words not marked last give no result
// a quantise word passes through the queue, the five-stage multiply pipeline
// and the output register, one word per cycle unless a stall or a summary
// holds the flow; a closing calibration word leaves the queue and runs
// through the bit-serial reciprocal divider, then its zero point through the
// same multiply pipeline; words behind it wait and item_stall rises once the
// four-entry queue is full; while result_stall is high with a result held,
// the output register, the pipeline and quantise words in the queue hold, a
// summary still leaves the queue; item words are taken until the queue fills
// reset clears the running minimum to the most positive value, the maximum to
// the most negative, the reciprocal, zero point and degenerate flag to zero,
// so quantise words before any calibration give code 0
`timescale 1ns / 1ps
`include "assert_macros.svh"

module minmax_uint8_quantizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  mmq_pkg::in_word_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output mmq_pkg::out_word_t result
);
	import mmq_pkg::*;

	// back-end sequencer for the summary path
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DIV    = 5'b00010,
		ST_ZP     = 5'b00100,
		ST_ZPWAIT = 5'b01000,
		ST_EMIT   = 5'b10000
	} seq_state_t;

	seq_state_t state_q;
	seq_state_t state_d;

	// queue between front and back
	logic  push;
	cmd_t  push_cmd;
	logic  pop;
	cmd_t  head;
	logic  fifo_empty;
	logic  fifo_full;

	// divider
	logic                div_start;
	logic [SAMPLE_W-1:0] div_range;
	div_stat_t           div_stat;
	logic [RECIP_W-1:0]  div_recip;
	logic [SCALE_W-1:0]  div_scale;

	// multiply pipeline
	aff_in_t  aff_in;
	aff_out_t aff_out;

	// latched quantisation parameters
	logic [RECIP_W-1:0]         recip_q;
	logic [CODE_W-1:0]          zp_q;
	logic                       range_zero_q;
	logic [SCALE_W-1:0]         scale_q;
	logic signed [SAMPLE_W-1:0] sum_min_q;
	logic signed [SAMPLE_W-1:0] sum_max_q;

	// output register
	out_word_t result_q;
	logic      result_valid_q;
	logic      adv;
	logic      load_code;
	logic      load_summary;
	logic      zp_capture;
	logic      head_quant;
	logic      head_summary;

	// the multiply pipeline and quantise pops move only when the output register can drain
	assign adv = !result_valid_q || !result_stall;

	mmq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	mmq_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (fifo_empty),
		.full     (fifo_full)
	);

	// head-of-queue decode, only acted on while idle
	assign head_quant   = (state_q == ST_IDLE) && !fifo_empty && !head.summary;
	assign head_summary = (state_q == ST_IDLE) && !fifo_empty && head.summary;

	assign pop       = head_summary || (head_quant && adv);
	assign div_start = head_summary;
	// max - min always fits unsigned in the sample width
	assign div_range = $unsigned(head.b) - $unsigned(head.a);

	mmq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.range  (div_range),
		.stat   (div_stat),
		.recip  (div_recip),
		.scale  (div_scale)
	);

	// zero point is the code of -min with zero offset, through the same pipeline
	always_comb begin
		aff_in.valid  = (head_quant || (state_q == ST_ZP)) && adv;
		aff_in.tag_zp = (state_q == ST_ZP);
		aff_in.deg    = range_zero_q;
		aff_in.recip  = recip_q;
		if (state_q == ST_ZP) begin
			aff_in.zp = '0;
			aff_in.x  = -MAG_W'(sum_min_q);
		end else begin
			aff_in.zp = zp_q;
			aff_in.x  = MAG_W'(head.a);
		end
	end

	mmq_affine u_affine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in     (aff_in),
		.out    (aff_out)
	);

	assign zp_capture   = adv && aff_out.valid && aff_out.tag_zp;
	assign load_code    = adv && aff_out.valid && !aff_out.tag_zp;
	assign load_summary = adv && (state_q == ST_EMIT);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head_summary) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_ZP;
				end
			end
			ST_ZP: begin
				if (adv) begin
					state_d = ST_ZPWAIT;
				end
			end
			ST_ZPWAIT: begin
				if (zp_capture) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (adv) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			recip_q        <= '0;
			zp_q           <= '0;
			range_zero_q   <= 1'b0;
			scale_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_DIV) && div_stat.done) begin
				recip_q      <= div_recip;
				range_zero_q <= div_stat.zero;
				scale_q      <= div_scale;
			end
			if (zp_capture) begin
				zp_q <= aff_out.code;
			end
			if (load_code || load_summary) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (div_start) begin
			sum_min_q <= head.a;
			sum_max_q <= head.b;
		end
		if (load_code) begin
			result_q.kind           <= KIND_CODE;
			result_q.code           <= aff_out.code;
			result_q.zero_point_out <= aff_out.zp;
			result_q.min_out        <= '0;
			result_q.max_out        <= '0;
			result_q.scale_out      <= '0;
			result_q.degenerate     <= aff_out.deg;
		end else if (load_summary) begin
			result_q.kind           <= KIND_SUMMARY;
			result_q.code           <= '0;
			result_q.zero_point_out <= zp_q;
			result_q.min_out        <= sum_min_q;
			result_q.max_out        <= sum_max_q;
			result_q.scale_out      <= scale_q;
			result_q.degenerate     <= range_zero_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`MMQ_ASSERT_IMPL(a_zp_only_when_waiting, aff_out.valid && aff_out.tag_zp, state_q == ST_ZPWAIT, "zero point result outside its wait state")
	`MMQ_ASSERT_IMPL(a_div_done_in_div, div_stat.done, state_q == ST_DIV, "divider finished outside divide state")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mmq_pkg::*;

	localparam int GAP_MAX        = 17;
	localparam int RANDOM_WORDS   = 1950;
	// the closing calibration word is the slowest path
	localparam int DRAIN_CYCLES   = 64;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam longint S_MAX = (longint'(1) << (SAMPLE_W - 1)) - 1;
	localparam longint S_MIN = -(longint'(1) << (SAMPLE_W - 1));
	localparam longint unsigned HALF_LSB  = 64'd1 << (PROD_SHIFT - 1);
	localparam longint unsigned RECIP_NUM = 64'd255 << PROD_SHIFT;
	localparam longint unsigned SCALE_SAT = 64'h1FFFF;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_word_t  item;
	logic      result_valid;
	logic      result_stall;
	out_word_t result;

	// words still owed by the block, oldest first
	out_word_t due_words[$];
	int        errors = 0;
	int        rand_sent = 0;

	// idling switches, one per side, drawn anew per data set in the random part
	bit          tx_idle = 1'b1;
	bit          rx_idle = 1'b1;
	int unsigned rx_wait = 0;

	// shadow of the calibration state and the latched parameters
	longint      run_min = S_MAX;
	longint      run_max = S_MIN;
	logic [31:0] q_recip = '0;
	logic [7:0]  q_zp    = '0;
	logic        q_deg   = 1'b0;

	minmax_uint8_quantizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// clamp(round(zp + x*recip), 0, 255), rounding half away from zero, exact
	function automatic logic [7:0] affine_code(longint x, logic [31:0] rc, logic [7:0] zpv);
		longint unsigned mag;
		longint unsigned prod;
		longint unsigned zs;
		longint unsigned r;
		mag  = (x < 0) ? -x : x;
		prod = mag * rc;
		zs   = 64'(zpv) << PROD_SHIFT;
		if (x >= 0) begin
			r = (prod + zs + HALF_LSB) >> PROD_SHIFT;
		end else if (zs < prod) begin
			return 8'd0;
		end else begin
			r = (zs - prod + HALF_LSB) >> PROD_SHIFT;
		end
		return (r > 255) ? 8'd255 : r[7:0];
	endfunction

	// runs one accepted input word through the shadow state and queues
	// the result word it owes, if any
	task automatic apply_word(in_word_t w);
		longint          x;
		longint unsigned span;
		longint unsigned rc;
		longint unsigned sc;
		out_word_t       e;
		x = longint'(w.sample);
		e = '0;
		if (w.mode == MODE_QUANT) begin
			e.kind           = KIND_CODE;
			e.code           = affine_code(x, q_recip, q_zp);
			e.zero_point_out = q_zp;
			e.degenerate     = q_deg;
			due_words.push_back(e);
		end else begin
			// min and max tracked independently
			if (x < run_min)
				run_min = x;
			if (x > run_max)
				run_max = x;
			if (w.last_item) begin
				span = run_max - run_min;
				sc   = 0;
				if (span == 0) begin
					// zero range: parameters forced so every later code is 0
					q_deg   = 1'b1;
					q_recip = '0;
					q_zp    = '0;
				end else begin
					rc      = (RECIP_NUM + span / 2) / span;
					q_deg   = 1'b0;
					q_recip = (rc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rc[31:0];
					q_zp    = affine_code(-run_min, q_recip, 8'd0);
					sc      = (span + 127) / 255;
					if (sc > SCALE_SAT)
						sc = SCALE_SAT;
				end
				e.kind           = KIND_SUMMARY;
				e.zero_point_out = q_zp;
				e.min_out        = run_min[SAMPLE_W-1:0];
				e.max_out        = run_max[SAMPLE_W-1:0];
				e.scale_out      = sc[SCALE_W-1:0];
				e.degenerate     = q_deg;
				due_words.push_back(e);
				// next data set starts afresh
				run_min = S_MAX;
				run_max = S_MIN;
			end
		end
	endtask

	// sends one word after a random gap and waits for it to be taken
	task automatic send_word(input logic mode, input longint s, input logic last);
		in_word_t    w;
		int unsigned gap;
		w.mode      = mode;
		w.sample    = s[SAMPLE_W-1:0];
		w.last_item = last;
		gap = tx_idle ? $urandom_range(0, GAP_MAX) : 0;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item       <= w;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		apply_word(w);
	endtask

	// holds the sender off until every owed word has come back
	task automatic wait_drained();
		item_valid <= 1'b0;
		do
			@(posedge clk);
		while (due_words.size() != 0);
	endtask

	function automatic longint rand_sample();
		logic signed [SAMPLE_W-1:0] v;
		v = SAMPLE_W'($urandom);
		return v;
	endfunction

	function automatic longint in_range(longint lo, longint hi);
		return lo + longint'($urandom_range(0, int'(hi - lo)));
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t mismatch on %s: expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_word(out_word_t got);
		out_word_t want;
		if (due_words.size() == 0) begin
			$display("%0t unexpected result word: expected none, actual %p", $time, got);
			errors++;
		end else begin
			want = due_words.pop_front();
			compare_field("kind", 32'(want.kind), 32'(got.kind));
			compare_field("code", 32'(want.code), 32'(got.code));
			compare_field("zero_point_out", 32'(want.zero_point_out),
				32'(got.zero_point_out));
			compare_field("min_out", 32'(want.min_out), 32'(got.min_out));
			compare_field("max_out", 32'(want.max_out), 32'(got.max_out));
			compare_field("scale_out", 32'(want.scale_out), 32'(got.scale_out));
			compare_field("degenerate", 32'(want.degenerate), 32'(got.degenerate));
		end
	endtask

	// receiving side: checks each accepted word, then stalls for a random
	// number of cycles before taking the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				check_word(result);
				rx_wait = rx_idle ? $urandom_range(0, GAP_MAX) : 0;
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			result_stall <= (rx_wait != 0);
		end
	end

	// quantise words before any calibration use the reset parameters
	task automatic test_uncalibrated();
		send_word(MODE_QUANT, S_MAX, 1'b1);
		send_word(MODE_QUANT, S_MIN, 1'b0);
		wait_drained();
	endtask

	// one-word data set: zero range, flag set and every later code 0
	task automatic test_degenerate();
		send_word(MODE_CAL, 64'sh1234, 1'b1);
		send_word(MODE_QUANT, S_MAX, 1'b0);
		send_word(MODE_QUANT, -1, 1'b1);
		wait_drained();
	endtask

	// widest range: sample extremes, and a calibration word with no result
	task automatic test_full_range();
		send_word(MODE_CAL, S_MIN, 1'b0);
		send_word(MODE_CAL, S_MAX, 1'b1);
		send_word(MODE_QUANT, S_MIN, 1'b0);
		send_word(MODE_QUANT, S_MAX, 1'b0);
		send_word(MODE_QUANT, 0, 1'b1);
		send_word(MODE_QUANT, -1, 1'b0);
		wait_drained();
	endtask

	// range of one lsb: reciprocal saturates, codes below the range clamp at 0
	task automatic test_tiny_range();
		send_word(MODE_CAL, 0, 1'b0);
		send_word(MODE_CAL, 1, 1'b1);
		send_word(MODE_QUANT, 0, 1'b0);
		send_word(MODE_QUANT, 1, 1'b0);
		send_word(MODE_QUANT, 2, 1'b0);
		send_word(MODE_QUANT, -1, 1'b0);
		wait_drained();
	endtask

	// all-positive range clamps the zero point at 0, all-negative at 255
	task automatic test_one_sided();
		send_word(MODE_CAL, 1000, 1'b0);
		send_word(MODE_CAL, 5000, 1'b1);
		send_word(MODE_QUANT, 3000, 1'b0);
		send_word(MODE_CAL, -5000, 1'b0);
		send_word(MODE_CAL, -1000, 1'b1);
		send_word(MODE_QUANT, -3000, 1'b0);
		wait_drained();
	endtask

	// data sets of random width and position, each followed by a burst of
	// quantise words mostly around the calibrated range; a few sets are
	// left open, and stray calibration words act as noise
	task automatic test_random_sets();
		longint lo;
		longint hi;
		longint span;
		longint pad;
		longint x;
		int     n_cal;
		int     n_q;
		while (rand_sent < RANDOM_WORDS) begin
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 9) == 0)
				wait_drained();
			case ($urandom_range(0, 3))
				0:       span = $urandom_range(0, 8);
				1:       span = $urandom_range(0, 4000);
				2:       span = $urandom_range(0, 1 << 18);
				default: span = $urandom_range(0, (1 << SAMPLE_W) - 1);
			endcase
			lo = rand_sample();
			hi = lo + span;
			if (hi > S_MAX) begin
				hi = S_MAX;
				lo = hi - span;
			end
			n_cal = $urandom_range(1, 12);
			for (int i = 0; i < n_cal; i++) begin
				if (i == 0)
					x = lo;
				else if (i == 1 && $urandom_range(0, 1))
					x = hi;
				else
					x = in_range(lo, hi);
				// now and then the set is never closed and runs into the next
				send_word(MODE_CAL, x, (i == n_cal - 1) && ($urandom_range(0, 11) != 0));
			end
			n_q = $urandom_range(0, 40);
			pad = span / 4 + 1;
			for (int j = 0; j < n_q; j++) begin
				if ($urandom_range(0, 24) == 0) begin
					send_word(MODE_CAL, rand_sample(), 1'b0);
				end else begin
					if ($urandom_range(0, 4) == 0)
						x = rand_sample();
					else
						x = in_range((lo - pad < S_MIN) ? S_MIN : lo - pad,
							(hi + pad > S_MAX) ? S_MAX : hi + pad);
					send_word(MODE_QUANT, x, 1'($urandom_range(0, 1)));
				end
			end
			rand_sent += n_cal + n_q;
		end
	endtask

	// watchdog: ends the run when nothing moves on either channel for too long
	initial begin
		int stuck;
		stuck = 0;
		while (stuck < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("[minmax_uint8_quantizer] ERROR");
		$finish;
	end

	initial begin
		arst_n       <= 1'b0;
		item_valid   <= 1'b0;
		item         <= '0;
		result_stall <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_uncalibrated();
		test_degenerate();
		test_full_range();
		test_tiny_range();
		test_one_sided();
		test_random_sets();

		// everything sent: wait for the owed words, then watch for strays
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[minmax_uint8_quantizer] OK");
		else
			$display("[minmax_uint8_quantizer] ERROR");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl
rtl/mmq_pkg.sv
rtl/mmq_front.sv
rtl/mmq_fifo.sv
rtl/mmq_div.sv
rtl/mmq_affine.sv
rtl/minmax_uint8_quantizer.sv
tb/tb_top.sv
